// ===== rtl/sde_pkg.sv =====
`default_nettype none

package sde_pkg;

	// Default sizes of the graph.
	localparam int MaxVerticesDef = 64;
	localparam int WeightBitsDef  = 16;

	// Fixed field widths of the streams.
	localparam int VertexW = 6;
	localparam int WeightW = 16;
	localparam int CountW  = 7;
	localparam int DistW   = 22;

	// Request codes.
	localparam logic [1:0] ReqAdd    = 2'd0;
	localparam logic [1:0] ReqRemove = 2'd1;
	localparam logic [1:0] ReqQuery  = 2'd2;
	localparam logic [1:0] ReqUnused = 2'd3;

	// Status codes.
	localparam logic [1:0] StOk       = 2'd0;
	localparam logic [1:0] StRange    = 2'd1;
	localparam logic [1:0] StDup      = 2'd2;
	localparam logic [1:0] StNotFound = 2'd3;

	// Configuration register indexes.
	localparam logic CfgVertexCount = 1'b0;
	localparam logic CfgDirected    = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/sde_alu.sv =====
`default_nettype none

// Shared add and compare unit: sum = a + b, lt = (a + b) < c.
module sde_alu #(
	parameter int DW = 22
) (
	input  wire logic [DW-1:0] a,
	input  wire logic [DW-1:0] b,
	input  wire logic [DW-1:0] c,
	output logic      [DW-1:0] sum,
	output logic               lt
);

	logic [DW:0] full;

	// One adder followed by one magnitude compare.
	always_comb begin
		full = {1'b0, a} + {1'b0, b};
		sum  = full[DW-1:0];
		lt   = full < {1'b0, c};
	end

endmodule

`default_nettype wire

// ===== rtl/shortest_distance_engine_core.sv =====
`default_nettype none

// Channel  Dir  Handshake          Payload
// s        in   s_tvalid/s_tready  s_tuser: req_type; s_tdata: from, to, weight
// m        out  m_tvalid/m_tready  m_tdata: status, reachable, distance
// cfg      in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A rejected or unused request goes straight to FIN; an edge update reads and checks the
// edge (E_RD, E_CHK) and, when mirrored, writes the reverse edge (E_REV) before FIN; a
// query's time grows with the vertices in use and reached, set by one read port per memory.
// After reset a clearing pass sweeps every entry of the edge store while s_tready
// stays low; cfg writes are taken.
// A new request is taken while a finished result still waits on m.
module shortest_distance_engine_core #(
	parameter int MAX_VERTICES = sde_pkg::MaxVerticesDef,
	parameter int WEIGHT_BITS  = sde_pkg::WeightBitsDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // from_vertex, to_vertex, edge_weight, zero fill
	input  wire logic [1:0]  s_tuser,   // req_type
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [31:0] m_tdata,   // status, reachable, distance, zero fill
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data
);

	localparam int VB = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int AW = 2 * VB;
	localparam int WB = WEIGHT_BITS;
	localparam int DW = WB + VB;
	localparam int ESIZE = 1 << AW;

	typedef enum logic [3:0] {
		CLEAR, IDLE, E_RD, E_CHK, E_REV, Q_INIT, SCAN, SCAN_END, SCAN_DEC,
		RELAX, RELAX_END, RES, RES2, FIN
	} state_t;

	state_t st_q;

	// Configuration registers.
	logic [6:0] vcount_q;
	logic       directed_q;

	// Request registers.
	logic [1:0]    req_q;
	logic [VB-1:0] a_q, b_q, u_q, v_q, v_s1;
	logic [WB-1:0] w_q;
	logic [CW-1:0] n_q;
	logic          vld_s1, found_q;
	logic [DW-1:0] best_q, du_q;
	logic [AW-1:0] clr_q;
	logic [MAX_VERTICES-1:0] settled_q, tvalid_q;

	// Result registers.
	logic [1:0]    status_q;
	logic          reach_q;
	logic [DW-1:0] dist_q;
	logic          m_tvalid_q;
	logic [31:0]   m_tdata_q;

	// Memories.
	logic [WB:0]   edge_mem_q [ESIZE];
	logic [WB:0]   em_rdata_q;
	logic [DW-1:0] td_mem_q [MAX_VERTICES];
	logic [DW-1:0] td_rdata_q;

	logic          em_we, td_we;
	logic [AW-1:0] em_raddr, em_waddr;
	logic [WB:0]   em_wdata;
	logic [VB-1:0] td_raddr, td_waddr;
	logic [DW-1:0] td_wdata;
	logic [DW-1:0] alu_a, alu_b, alu_c, alu_sum;
	logic          alu_lt, relax_hit, scan_hit, last_v, relaxing;

	// Input field decode.
	logic [5:0]    in_from, in_to;
	logic [15:0]   in_n, in_a, in_b;
	logic [CW-1:0] in_ncw;
	logic [VB+5:0] a_ext, b_ext;
	logic [WB+15:0] w_ext;
	logic [DW+21:0] dist_ext;

	always_comb begin
		in_from = s_tdata[5:0];
		in_to   = s_tdata[11:6];
		in_n    = (16'(vcount_q) > 16'(MAX_VERTICES)) ? 16'(MAX_VERTICES) : 16'(vcount_q);
		in_ncw  = in_n[CW-1:0];
		in_a    = 16'(in_from);
		in_b    = 16'(in_to);
		a_ext   = {{VB{1'b0}}, in_from};
		b_ext   = {{VB{1'b0}}, in_to};
		w_ext   = {{WB{1'b0}}, s_tdata[27:12]};
		last_v  = 16'(v_q) == (16'(n_q) - 16'd1);
		relaxing = (st_q == RELAX) || (st_q == RELAX_END);
	end

	sde_alu #(.DW(DW)) u_alu (
		.a(alu_a), .b(alu_b), .c(alu_c), .sum(alu_sum), .lt(alu_lt)
	);

	// Memory port steering and the relax and scan decisions.
	always_comb begin
		em_raddr = {u_q, v_q};
		em_we    = 1'b0;
		em_waddr = {a_q, b_q};
		em_wdata = '0;
		td_raddr = v_q;
		if (st_q == E_RD) begin
			em_raddr = {a_q, b_q};
		end
		if (st_q == RES) begin
			td_raddr = b_q;
		end
		case (st_q)
			CLEAR: begin
				em_we    = 1'b1;
				em_waddr = clr_q;
			end
			E_CHK: begin
				if (req_q == sde_pkg::ReqAdd && !em_rdata_q[WB]) begin
					em_we    = 1'b1;
					em_wdata = {1'b1, w_q};
				end else if (req_q == sde_pkg::ReqRemove && em_rdata_q[WB]) begin
					em_we = 1'b1;
				end
			end
			E_REV: begin
				em_we    = 1'b1;
				em_waddr = {b_q, a_q};
				em_wdata = (req_q == sde_pkg::ReqAdd) ? {1'b1, w_q} : '0;
			end
			default: begin
			end
		endcase

		if (relaxing) begin
			alu_a = du_q;
			alu_b = {{VB{1'b0}}, em_rdata_q[WB-1:0]};
			alu_c = td_rdata_q;
		end else begin
			alu_a = td_rdata_q;
			alu_b = '0;
			alu_c = best_q;
		end
		relax_hit = relaxing && vld_s1 && em_rdata_q[WB] && !settled_q[v_s1] &&
			(!tvalid_q[v_s1] || alu_lt);
		scan_hit = vld_s1 && tvalid_q[v_s1] && !settled_q[v_s1] && (!found_q || alu_lt);

		if (st_q == Q_INIT) begin
			td_we    = 1'b1;
			td_waddr = a_q;
			td_wdata = '0;
		end else begin
			td_we    = relax_hit;
			td_waddr = v_s1;
			td_wdata = alu_sum;
		end
	end

	// Edge store: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (em_we) begin
			edge_mem_q[em_waddr] <= em_wdata;
		end
		em_rdata_q <= edge_mem_q[em_raddr];
	end

	// Tentative distance memory.
	always_ff @(posedge clk) begin
		if (td_we) begin
			td_mem_q[td_waddr] <= td_wdata;
		end
		td_rdata_q <= td_mem_q[td_raddr];
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q   <= '0;
			directed_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == sde_pkg::CfgVertexCount) begin
				vcount_q <= cfg_data;
			end else begin
				directed_q <= cfg_data[0];
			end
		end
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= CLEAR;
			clr_q      <= '0;
			vld_s1     <= 1'b0;
			found_q    <= 1'b0;
			settled_q  <= '0;
			tvalid_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (st_q == FIN && (!m_tvalid_q || m_tready)) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (td_we && st_q != Q_INIT) begin
				tvalid_q[v_s1] <= 1'b1;
			end
			case (st_q)
				CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						st_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						req_q    <= s_tuser;
						a_q      <= a_ext[VB-1:0];
						b_q      <= b_ext[VB-1:0];
						w_q      <= w_ext[WB-1:0];
						n_q      <= in_ncw;
						status_q <= (s_tuser != sde_pkg::ReqUnused &&
							(in_a >= in_n || in_b >= in_n)) ? sde_pkg::StRange : sde_pkg::StOk;
						reach_q  <= 1'b0;
						dist_q   <= '0;
						if (s_tuser == sde_pkg::ReqUnused) begin
							st_q <= FIN;
						end else if (in_a >= in_n || in_b >= in_n) begin
							st_q <= FIN;
						end else if (s_tuser == sde_pkg::ReqQuery) begin
							st_q <= Q_INIT;
						end else begin
							st_q <= E_RD;
						end
					end
				end
				E_RD: begin
					st_q <= E_CHK;
				end
				E_CHK: begin
					if (req_q == sde_pkg::ReqAdd && em_rdata_q[WB]) begin
						status_q <= sde_pkg::StDup;
						st_q     <= FIN;
					end else if (req_q == sde_pkg::ReqRemove && !em_rdata_q[WB]) begin
						status_q <= sde_pkg::StNotFound;
						st_q     <= FIN;
					end else begin
						st_q <= directed_q ? FIN : E_REV;
					end
				end
				E_REV: begin
					st_q <= FIN;
				end
				Q_INIT: begin
					settled_q <= '0;
					tvalid_q  <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_q;
					found_q   <= 1'b0;
					vld_s1    <= 1'b0;
					v_q       <= '0;
					st_q      <= SCAN;
				end
				SCAN, SCAN_END: begin
					if (scan_hit) begin
						found_q <= 1'b1;
						best_q  <= td_rdata_q;
						u_q     <= v_s1;
					end
					v_s1   <= v_q;
					vld_s1 <= (st_q == SCAN);
					v_q    <= v_q + 1'b1;
					if (st_q == SCAN_END) begin
						st_q <= SCAN_DEC;
					end else if (last_v) begin
						st_q <= SCAN_END;
					end
				end
				SCAN_DEC: begin
					v_q    <= '0;
					vld_s1 <= 1'b0;
					if (!found_q) begin
						st_q <= RES;
					end else begin
						settled_q[u_q] <= 1'b1;
						du_q           <= best_q;
						st_q           <= RELAX;
					end
				end
				RELAX, RELAX_END: begin
					v_s1   <= v_q;
					vld_s1 <= (st_q == RELAX);
					if (st_q == RELAX_END) begin
						v_q     <= '0;
						found_q <= 1'b0;
						st_q    <= SCAN;
					end else begin
						v_q <= v_q + 1'b1;
						if (last_v) begin
							st_q <= RELAX_END;
						end
					end
				end
				RES: begin
					st_q <= RES2;
				end
				RES2: begin
					reach_q <= tvalid_q[b_q];
					dist_q  <= tvalid_q[b_q] ? td_rdata_q : '0;
					st_q    <= FIN;
				end
				FIN: begin
					if (!m_tvalid_q || m_tready) begin
						m_tdata_q <= {7'd0, dist_ext[21:0], reach_q, status_q};
						st_q      <= IDLE;
					end
				end
				default: begin
					st_q <= IDLE;
				end
			endcase
		end
	end

	assign dist_ext  = {22'd0, dist_q};
	assign s_tready  = (st_q == IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// No request is taken before the clearing pass is over.
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == CLEAR) |-> !s_tready)
		else $error("request taken during edge store clearing");

	// The edge store is never written while idle.
	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == IDLE) |-> !em_we)
		else $error("edge store written while idle");

	// The start vertex stays reached during the whole search.
	a_src_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == SCAN || st_q == RELAX) |-> tvalid_q[a_q])
		else $error("start vertex lost its tentative distance");

	// No more vertices are settled than are in use.
	a_settled_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == SCAN) |-> ($countones(settled_q) <= int'(n_q)))
		else $error("settled more vertices than in use");

endmodule

`default_nettype wire
